// ===== sv/target_lock_monitor_top_defines.svh =====
// Assertion macros shared by the target lock monitor RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TARGET_LOCK_MONITOR_TOP_DEFINES_SVH
`define TARGET_LOCK_MONITOR_TOP_DEFINES_SVH

// Generic clocked check with an explicit clock and active-low reset.
`define TLM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on the block clock, off while reset is asserted.
`define TLM_ASSERT(label, prop, msg) \
    `TLM_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== sv/tlm_pkg.sv =====
// Types and constants of the target lock monitor: item, result and
// configuration write payloads, register indexes and reset values.
package tlm_pkg;

    localparam int unsigned RUN_W   = 16;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned WEIGHT_W = 17;
    localparam int unsigned CFG_IDX_W = 4;

    // Item kinds carried in the mode field.
    localparam logic MODE_OBSERVATION = 1'b0;
    localparam logic MODE_TICK        = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_RUN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_RUN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT      = 4'd3;

    // Reset values of the configuration registers.
    localparam logic [RUN_W-1:0]    LOCK_RUN_RST = 16'd5;
    localparam logic [RUN_W-1:0]    LOST_RUN_RST = 16'd10;
    localparam logic [RUN_W-1:0]    TIMEOUT_RST  = 16'd1000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 17'd32768;

    localparam logic [WEIGHT_W-1:0] Q16_ONE   = 17'd65536;
    localparam logic [RUN_W-1:0]    RUN_MAX   = 16'hFFFF;
    localparam logic [WORD_W-1:0]   FAULT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                mode;
        logic                detected;
        logic [COORD_W-1:0]  center_x;
        logic [COORD_W-1:0]  center_y;
        logic [COORD_W-1:0]  confidence;
        logic [WORD_W-1:0]   frame_number;
        logic [COORD_W-1:0]  frame_cols;
        logic [COORD_W-1:0]  frame_rows;
        logic [7:0]          num_candidates;
    } t_item;

    typedef struct packed {
        logic [1:0]          track_state;
        logic                locked_valid;
        logic [RUN_W-1:0]    hit_run;
        logic [RUN_W-1:0]    miss_run;
        logic [COORD_W-1:0]  smooth_x;
        logic [COORD_W-1:0]  smooth_y;
        logic [COORD_W-1:0]  smooth_confidence;
        logic [WORD_W-1:0]   last_frame_number;
        logic [COORD_W-1:0]  last_frame_cols;
        logic [COORD_W-1:0]  last_frame_rows;
        logic [WORD_W-1:0]   last_seen_time;
        logic [WORD_W-1:0]   fault_total;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WEIGHT_W-1:0]  value;
    } t_cfg_wr;

endpackage

// ===== sv/tlm_chan_if.sv =====
// Valid/ready channel interface used for items, results and configuration.
// The payload type is a parameter; payload structs come from tlm_pkg.
interface tlm_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/target_lock_monitor_top.sv =====
// Target lock monitor: tracks hit and miss runs, smoothed position and
// confidence, silence timeout and fault count; one status result per item.
// An accepted item waits in the input register; its result is then held in the result register.
// Throughput: one item per cycle, set by the single update stage between the
// input register and the result register; a stalled result holds that stage.
// Reset (i_rst_n, synchronous, active low) clears all state and restores configuration.
`include "target_lock_monitor_top_defines.svh"

module target_lock_monitor_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlm_chan_if.sink   i_item,
    tlm_chan_if.source o_result,
    tlm_chan_if.sink   i_cfg
);

    // Tracking state, in the encoding that the result field reports.
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_ACQUIRING = 2'd1,
        ST_LOCKED    = 2'd2,
        ST_LOST      = 2'd3
    } t_track_state;

    // Exponential smoothing step, rounded to nearest with halves upward.
    // It is written as old + (sample - old) * alpha so that only one
    // multiplier per channel is needed; the true result always fits 16 bits,
    // so the sum may be taken modulo 2^16.
    function automatic logic [15:0] blend(input logic [15:0] old_v,
                                          input logic [15:0] smp_v,
                                          input logic [16:0] alpha);
        logic signed [16:0] diff;
        logic signed [17:0] alpha_s;
        logic signed [34:0] prod;
        logic signed [34:0] acc;
        diff    = $signed({1'b0, smp_v}) - $signed({1'b0, old_v});
        alpha_s = $signed({1'b0, alpha});
        prod    = 35'(diff) * 35'(alpha_s);
        acc     = prod + 35'sd32768;
        return old_v + acc[31:16];
    endfunction

    // Configuration registers. The user must write them only while the block is idle;
    // the block itself does not enforce this, and the port is always ready.
    logic [tlm_pkg::RUN_W-1:0]    r_lock_run;
    logic [tlm_pkg::RUN_W-1:0]    r_lost_run;
    logic [tlm_pkg::RUN_W-1:0]    r_timeout;
    logic [tlm_pkg::WEIGHT_W-1:0] r_weight;

    // Input register stage.
    logic           r_in_valid;
    tlm_pkg::t_item r_in_data;

    // Result register stage.
    logic             r_out_valid;
    tlm_pkg::t_result r_out_data;

    // Tracking state and its next values.
    t_track_state                r_state,    n_state;
    logic [tlm_pkg::RUN_W-1:0]   r_hit,      n_hit;
    logic [tlm_pkg::RUN_W-1:0]   r_miss,     n_miss;
    logic                        r_primed,   n_primed;
    logic [tlm_pkg::COORD_W-1:0] r_avg_x,    n_avg_x;
    logic [tlm_pkg::COORD_W-1:0] r_avg_y,    n_avg_y;
    logic [tlm_pkg::COORD_W-1:0] r_avg_conf, n_avg_conf;
    logic [tlm_pkg::WORD_W-1:0]  r_time,     n_time;
    logic [tlm_pkg::WORD_W-1:0]  r_last_obs, n_last_obs;
    logic                        r_seen,     n_seen;
    logic [tlm_pkg::WORD_W-1:0]  r_seen_time, n_seen_time;
    logic [tlm_pkg::WORD_W-1:0]  r_frame,    n_frame;
    logic [tlm_pkg::COORD_W-1:0] r_cols,     n_cols;
    logic [tlm_pkg::COORD_W-1:0] r_rows,     n_rows;
    logic [tlm_pkg::WORD_W-1:0]  r_fault,    n_fault;

    logic                          w_adv;
    logic                          w_tick;
    logic                          w_fault_inc;
    logic [tlm_pkg::WEIGHT_W-1:0]  w_alpha;
    logic [tlm_pkg::WORD_W-1:0]    w_age;
    tlm_pkg::t_result              w_result;

    // The update stage moves whenever it holds an item and the result
    // register is empty or being emptied in this cycle. The input register
    // may refill in the same cycle, so items can follow back to back.
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // The held item is a millisecond tick rather than an observation.
    assign w_tick = (r_in_data.mode == tlm_pkg::MODE_TICK);

    // A weight above one behaves as exactly one.
    assign w_alpha = (r_weight > tlm_pkg::Q16_ONE) ? tlm_pkg::Q16_ONE : r_weight;

    // Silence age after this tick's clock advance, modulo 2^32.
    assign w_age = (r_time + 32'd1) - r_last_obs;

    always_comb begin
        n_state     = r_state;
        n_hit       = r_hit;
        n_miss      = r_miss;
        n_primed    = r_primed;
        n_avg_x     = r_avg_x;
        n_avg_y     = r_avg_y;
        n_avg_conf  = r_avg_conf;
        n_time      = r_time;
        n_last_obs  = r_last_obs;
        n_seen      = r_seen;
        n_seen_time = r_seen_time;
        n_frame     = r_frame;
        n_cols      = r_cols;
        n_rows      = r_rows;
        w_fault_inc = 1'b0;

        if (w_tick) begin
            // Time tick: advance the clock, then check for a silent target.
            n_time = r_time + 32'd1;
            if (r_seen && (w_age >= {16'd0, r_timeout}) && (r_state != ST_LOST)) begin
                n_state     = ST_LOST;
                n_hit       = '0;
                w_fault_inc = 1'b1;
            end
        end else begin
            // Observation: record frame details whether or not it was a hit.
            n_last_obs  = r_time;
            n_seen      = 1'b1;
            n_frame     = r_in_data.frame_number;
            n_cols      = r_in_data.frame_cols;
            n_rows      = r_in_data.frame_rows;
            w_fault_inc = (r_in_data.num_candidates > 8'd1);

            if (r_in_data.detected) begin
                n_hit       = (r_hit == tlm_pkg::RUN_MAX) ? r_hit : r_hit + 16'd1;
                n_miss      = '0;
                n_seen_time = r_time;
                if (!r_primed) begin
                    // The first detection loads the averages directly.
                    n_avg_x    = r_in_data.center_x;
                    n_avg_y    = r_in_data.center_y;
                    n_avg_conf = r_in_data.confidence;
                    n_primed   = 1'b1;
                end else begin
                    n_avg_x    = blend(r_avg_x, r_in_data.center_x, w_alpha);
                    n_avg_y    = blend(r_avg_y, r_in_data.center_y, w_alpha);
                    n_avg_conf = blend(r_avg_conf, r_in_data.confidence, w_alpha);
                end
                n_state = (n_hit >= r_lock_run) ? ST_LOCKED : ST_ACQUIRING;
            end else begin
                n_hit  = '0;
                n_miss = (r_miss == tlm_pkg::RUN_MAX) ? r_miss : r_miss + 16'd1;
                // A long enough miss run loses the target; a shorter one
                // only falls back to searching when not already locked.
                if (n_miss >= r_lost_run) begin
                    n_state = ST_LOST;
                end else if (r_state != ST_LOCKED) begin
                    n_state = ST_SEARCHING;
                end
            end
        end

        n_fault = (w_fault_inc && (r_fault != tlm_pkg::FAULT_MAX)) ? r_fault + 32'd1 : r_fault;
    end

    // The result reports the state after this item's own update.
    always_comb begin
        w_result.track_state       = n_state;
        w_result.locked_valid      = (n_state == ST_LOCKED);
        w_result.hit_run           = n_hit;
        w_result.miss_run          = n_miss;
        w_result.smooth_x          = n_avg_x;
        w_result.smooth_y          = n_avg_y;
        w_result.smooth_confidence = n_avg_conf;
        w_result.last_frame_number = n_frame;
        w_result.last_frame_cols   = n_cols;
        w_result.last_frame_rows   = n_rows;
        w_result.last_seen_time    = n_seen_time;
        w_result.fault_total       = n_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_run  <= tlm_pkg::LOCK_RUN_RST;
            r_lost_run  <= tlm_pkg::LOST_RUN_RST;
            r_timeout   <= tlm_pkg::TIMEOUT_RST;
            r_weight    <= tlm_pkg::WEIGHT_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_SEARCHING;
            r_hit       <= '0;
            r_miss      <= '0;
            r_primed    <= 1'b0;
            r_avg_x     <= '0;
            r_avg_y     <= '0;
            r_avg_conf  <= '0;
            r_time      <= '0;
            r_last_obs  <= '0;
            r_seen      <= 1'b0;
            r_seen_time <= '0;
            r_frame     <= '0;
            r_cols      <= '0;
            r_rows      <= '0;
            r_fault     <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    tlm_pkg::CFG_LOCK_RUN: r_lock_run <= i_cfg.data.value[15:0];
                    tlm_pkg::CFG_LOST_RUN: r_lost_run <= i_cfg.data.value[15:0];
                    tlm_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg.data.value[15:0];
                    tlm_pkg::CFG_WEIGHT:   r_weight   <= i_cfg.data.value;
                    default: ;
                endcase
            end

            if (i_item.valid && i_item.ready) begin
                r_in_data <= i_item.data;
            end
            r_in_valid <= (i_item.valid && i_item.ready) || (r_in_valid && !w_adv);

            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_result;
                r_state     <= n_state;
                r_hit       <= n_hit;
                r_miss      <= n_miss;
                r_primed    <= n_primed;
                r_avg_x     <= n_avg_x;
                r_avg_y     <= n_avg_y;
                r_avg_conf  <= n_avg_conf;
                r_time      <= n_time;
                r_last_obs  <= n_last_obs;
                r_seen      <= n_seen;
                r_seen_time <= n_seen_time;
                r_frame     <= n_frame;
                r_cols      <= n_cols;
                r_rows      <= n_rows;
                r_fault     <= n_fault;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A hit run and a miss run never stand at the same time.
    `TLM_ASSERT(a_runs_exclusive, (r_hit != '0) |-> (r_miss == '0), "hit and miss runs overlap")
    // The averages are only loaded by a detection, which is an observation.
    `TLM_ASSERT(a_primed_seen, r_primed |-> r_seen, "smoothing primed without observation")
    // Tracking state moves only when an item passes the update stage.
    `TLM_ASSERT(a_state_hold, !w_adv |=> $stable({r_state, r_hit, r_fault}), "state moved idle")
    // A tick advances the millisecond clock by exactly one.
    `TLM_ASSERT(a_tick_time, w_adv && w_tick |=> r_time == $past(r_time) + 32'd1, "no tick step")
    // The fault total never goes down.
    `TLM_ASSERT(a_fault_mono, 1'b1 |=> (r_fault >= $past(r_fault)), "fault total decreased")

endmodule
